### hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

### hw/rtl/isort_pkg.sv
// shared types and constants of the insertion sort engine
// no dependencies
package isort_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;     // latch the incoming transaction
    logic drop;     // store full, note the discarded value
    logic rd_prev;  // read the entry below the insert position
    logic shift;    // move the entry up one place, read the next one down
    logic place;    // write the new value at the insert position
    logic emit_rd;  // read the next entry of the sorted run
    logic clear;    // end of run, empty the store
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic last;
    logic pos_zero;
    logic pos_one;
    logic greater;
    logic emit_end;
  } sts_t;

endpackage

### hw/rtl/isort_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module isort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/isort_ctrl.sv
// controller state machine of the insertion sort engine
// depends on isort_pkg
module isort_ctrl import isort_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TEST  = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        priority if (sts.full) begin
          cmd.drop   = 1'b1;
          state_next = sts.last ? S_EMIT : S_IDLE;
        end else if (sts.pos_zero) begin
          state_next = S_PLACE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.greater) begin
          cmd.shift  = 1'b1;
          state_next = sts.pos_one ? S_PLACE : S_CMP;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        cmd.emit_rd = 1'b1;
        if (sts.emit_end) begin
          cmd.clear  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/isort_dp.sv
// datapath of the insertion sort engine: element store, pointers, output stage
// depends on isort_pkg and isort_ram
module isort_dp import isort_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last_in,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic                     result_strobe,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     last_out,
  output logic                     dropped
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [DATA_W-1:0] v;
  logic                     last_flag;
  logic [AW-1:0]            pos;
  logic [AW-1:0]            k;
  logic [CW-1:0]            count;
  logic                     overflow;
  logic                     strobe;
  logic                     out_last;
  logic                     out_dropped;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  isort_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shift writes the entry read last cycle one place up
  assign ram_we    = cmd.shift | cmd.place;
  assign ram_waddr = pos;
  assign ram_wdata = cmd.shift ? ram_rdata : v;
  assign ram_re    = cmd.emit_rd | cmd.shift | cmd.rd_prev;

  always_comb begin
    priority if (cmd.emit_rd) begin
      ram_raddr = k;
    end else if (cmd.shift) begin
      ram_raddr = pos - AW'(2);
    end else begin
      ram_raddr = pos - AW'(1);
    end
  end

  assign sts.full     = (count == CW'(DEPTH));
  assign sts.last     = last_flag;
  assign sts.pos_zero = (pos == '0);
  assign sts.pos_one  = (pos == AW'(1));
  assign sts.greater  = ($signed(ram_rdata) > v);
  assign sts.emit_end = ((CW'(k) + CW'(1)) == count);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v         <= value;
      last_flag <= last_in;
      pos       <= count[AW-1:0];
    end else if (cmd.shift) begin
      pos <= pos - AW'(1);
    end
    if (cmd.emit_rd) begin
      out_last    <= sts.emit_end;
      out_dropped <= overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      k        <= '0;
      strobe   <= 1'b0;
    end else begin
      strobe <= cmd.emit_rd;
      if (cmd.place) begin
        count <= count + CW'(1);
      end
      if (cmd.drop) begin
        overflow <= 1'b1;
      end
      if (cmd.emit_rd) begin
        k <= k + AW'(1);
      end
      if (cmd.clear) begin
        count    <= '0;
        overflow <= 1'b0;
        k        <= '0;
      end
    end
  end

  assign result_strobe = strobe;
  assign sorted_value  = $signed(ram_rdata);
  assign last_out      = out_last;
  assign dropped       = out_dropped;

endmodule

### hw/rtl/insertion_sort_engine.sv
// top level of the insertion sort engine: controller plus datapath
// depends on isort_pkg, isort_ctrl, isort_dp, isort_ram and assert_macros.svh
//
// channel  handshake                 payload
// input    start, busy               value, last_in
// result   result_strobe (no stall)  sorted_value, last_out, dropped
//
// a transaction is taken when start is high and busy is low
// insert: accept, test for room, compare and shift up each stored entry larger than the
// value until a smaller or equal entry ends the walk, then place; a full store drops it
// a transaction marked last_in then emits n results on consecutive cycles,
// the first in the cycle after the emit phase starts (registered ram read)
// rst is synchronous; it empties the store and clears the overflow flag
// results cannot be held off, so nothing inside ever waits on the receiver
`include "assert_macros.svh"

module insertion_sort_engine import isort_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     last_in,
  output logic                     result_strobe,
  output logic signed [DATA_W-1:0] sorted_value,
  output logic                     last_out,
  output logic                     dropped
);

  cmd_t cmd;  // controller to datapath
  sts_t sts;  // datapath to controller

  // sequencing: accept, test for room, walk down the store, place, emit
  isort_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // store is kept sorted at all times, so emitting is a plain upward read
  isort_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .value         (value),
    .last_in       (last_in),
    .cmd           (cmd),
    .sts           (sts),
    .result_strobe (result_strobe),
    .sorted_value  (sorted_value),
    .last_out      (last_out),
    .dropped       (dropped)
  );

  // every result comes from a store read issued the cycle before
  `ASSERT_HOLDS(a_strobe_from_read, clk, rst, result_strobe |-> $past(cmd.emit_rd))
  // the end of a run is never followed directly by another result
  `ASSERT_HOLDS(a_run_ends, clk, rst, (result_strobe && last_out) |=> !result_strobe)
  // an accepted transaction always keeps the engine busy for the next cycle
  `ASSERT_HOLDS(a_accept_busy, clk, rst, (start && !busy) |=> busy)
  // only one store write source at a time
  `ASSERT_NEVER(a_one_writer, clk, rst, cmd.shift && cmd.place)

endmodule

### test/tb_insertion_sort_engine.sv
`timescale 1ns / 100ps
// testbench of the insertion sort engine: a sorted-run scoreboard class plus stimulus tasks
// depends on isort_pkg and the insertion_sort_engine rtl

class sort_scoreboard;
  typedef struct {
    logic signed [isort_pkg::DATA_W-1:0] val;
    logic                                last;
    logic                                drop;
  } run_entry_t;

  // local copy of the engine state
  logic signed [isort_pkg::DATA_W-1:0] store [isort_pkg::DEPTH_DEFAULT];
  int unsigned count;
  bit          overflow;
  run_entry_t  sorted_run [$];
  int          errors;

  function new();
    count    = 0;
    overflow = 0;
    errors   = 0;
  endfunction

  // place one accepted value; a transaction marked last releases the whole run
  function void note_input(logic signed [isort_pkg::DATA_W-1:0] v, logic last);
    int pos;
    run_entry_t e;
    if (count < isort_pkg::DEPTH_DEFAULT) begin
      pos = count;
      // equal entries stay below the new value
      while (pos > 0 && store[pos-1] > v) begin
        store[pos] = store[pos-1];
        pos--;
      end
      store[pos] = v;
      count++;
    end else begin
      overflow = 1;
    end
    if (last) begin
      for (int k = 0; k < count; k++) begin
        e.val  = store[k];
        e.last = (k + 1 == count);
        e.drop = overflow;
        sorted_run.push_back(e);
      end
      count    = 0;
      overflow = 0;
    end
  endfunction

  function void check_result(logic signed [isort_pkg::DATA_W-1:0] v, logic last, logic drop);
    run_entry_t e;
    if (sorted_run.size() == 0) begin
      $display("%0t unexpected result: expected none, actual value %0d last %0b dropped %0b",
               $time, v, last, drop);
      errors++;
      return;
    end
    e = sorted_run.pop_front();
    if (v !== e.val) begin
      $display("%0t sorted_value mismatch: expected %0d actual %0d", $time, e.val, v);
      errors++;
    end
    if (last !== e.last) begin
      $display("%0t last_out mismatch: expected %0b actual %0b", $time, e.last, last);
      errors++;
    end
    if (drop !== e.drop) begin
      $display("%0t dropped mismatch: expected %0b actual %0b", $time, e.drop, drop);
      errors++;
    end
  endfunction

  function int pending();
    return sorted_run.size();
  endfunction
endclass

module tb_insertion_sort_engine;
  import isort_pkg::*;

  localparam int CAP         = DEPTH_DEFAULT;
  localparam int ITEM_TARGET = 310;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic signed [DATA_W-1:0] value;
  logic                     last_in;
  logic                     result_strobe;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_out;
  logic                     dropped;

  sort_scoreboard sb;
  int             items_sent;
  bit             quiet_stretch;  // no sender gaps while set

  insertion_sort_engine #(.DEPTH(CAP)) uut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .last_in       (last_in),
    .result_strobe (result_strobe),
    .sorted_value  (sorted_value),
    .last_out      (last_out),
    .dropped       (dropped)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // results cannot be stalled, so every strobe is a finished transaction
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      sb.check_result(sorted_value, last_out, dropped);
    end
  end

  // sender gap: start low, noise on the payload
  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      start   <= 1'b0;
      value   <= $urandom;
      last_in <= 1'($urandom_range(1));
    end
  endtask

  // one input transaction, held until the engine takes it
  task automatic send_value(input logic signed [DATA_W-1:0] v, input logic l);
    @(negedge clk);
    start   <= 1'b1;
    value   <= v;
    last_in <= l;
    do @(posedge clk); while (busy);
    sb.note_input(v, l);
    items_sent++;
    if (!quiet_stretch && $urandom_range(99) < 6) begin
      idle($urandom_range(1, 4));
    end
  endtask

  // stop sending until the last sorted run has fully come out
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // mix of extremes, a narrow band for duplicates, and full-range values
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3:    return int'($urandom_range(8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) begin
      send_value(pick_value(), i == len - 1);
    end
  endtask

  initial begin : stimulus
    int sets;
    int pick;
    int len;
    sb            = new();
    rst           = 1'b1;
    start         = 1'b0;
    value         = '0;
    last_in       = 1'b0;
    items_sent    = 0;
    quiet_stretch = 1'b0;
    sets          = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // sets of one at both extremes
    send_value(32'sh8000_0000, 1'b1);
    send_value(32'sh7fff_ffff, 1'b1);
    // mixed signs, both extremes, equal values at the end of the set
    send_value(32'sd0, 1'b0);
    send_value(-32'sd1, 1'b0);
    send_value(32'sh7fff_ffff, 1'b0);
    send_value(32'sh8000_0000, 1'b0);
    send_value(32'sd7, 1'b0);
    send_value(32'sd7, 1'b1);
    drain();
    // descending fill of the whole store, then the end mark lands on a dropped value
    for (int i = 0; i <= CAP; i++) begin
      send_value(100 - i, i == CAP);
    end
    drain();

    // random sets: mostly mid-size, some of one, some exactly full, some overflowing
    while (items_sent < ITEM_TARGET) begin
      quiet_stretch = (items_sent >= 120 && items_sent < 200);
      pick = $urandom_range(99);
      if (pick < 10)      len = 1;
      else if (pick < 20) len = CAP;
      else if (pick < 30) len = $urandom_range(CAP + 1, CAP + 4);
      else                len = $urandom_range(2, CAP - 1);
      send_set(len);
      sets++;
      if (sets % 8 == 0) drain();
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    // catch any stray result after the last run
    repeat (CAP + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
